// ===== sv/avsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsb_pkg
// Shared types and constants for the accelerometer averaging block.
// ----------------------------------------------------------------------------
package avsb_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned PROD_W  = SUM_W + SCALE_W;
  // numerator after the fixed divide by 256
  localparam int unsigned NUM_W   = PROD_W - 8;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]   MAX_SAMPLES = 8'd255;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd658103;
  localparam logic [STEP_W-1:0]  DIV_STEPS   = 6'd40;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_EVAL  = 2'd1,
    MODE_CAL   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X = 2'd0,
    REG_SCALE_Y = 2'd1,
    REG_SCALE_Z = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic add;
    logic clear;
    logic capture;
    logic load;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic cal;
    logic empty;
    logic dropped;
  } merge_ctrl_t;

endpackage

// ===== sv/avsb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsb_lane
// One axis: saturating sum, scale multiply and bit-serial rounded divide.
// ----------------------------------------------------------------------------
module avsb_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  avsb_pkg::lane_ctrl_t          ctrl_i,
  input  logic signed [avsb_pkg::RAW_W-1:0]   raw_i,
  input  logic [avsb_pkg::SCALE_W-1:0]  scale_i,
  input  logic [avsb_pkg::CNT_W-1:0]    count_i,
  output logic signed [avsb_pkg::Q_W-1:0]     avg_o
);
  import avsb_pkg::*;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0]        sum_mag;
  logic [PROD_W-1:0]       prod_q;
  logic                    neg_q;
  logic [PROD_W-1:0]       num_full;
  logic [NUM_W-1:0]        num_q;
  logic [CNT_W-1:0]        rem_q;
  logic [CNT_W:0]          rem_sh;
  logic [CNT_W:0]          rem_sub;
  logic                    q_bit;

  assign sum_wide = {sum_q[SUM_W-1], sum_q}
                  + {{(SUM_W+1-RAW_W){raw_i[RAW_W-1]}}, raw_i};

  always_comb begin
    if (sum_wide > (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}}) &&
        !sum_wide[SUM_W]) begin
      sum_d = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (sum_wide[SUM_W] && !sum_wide[SUM_W-1]) begin
      sum_d = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_d = sum_wide[SUM_W-1:0];
    end
  end

  // magnitude fits 24 bits since the sum is at most 2^23 in size
  assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  // round half up before the fixed /256
  assign num_full = prod_q + PROD_W'({count_i, 7'd0});

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, count_i};
  assign q_bit   = (rem_sh >= {1'b0, count_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clear || ctrl_i.capture) begin
      sum_q <= '0;
    end else if (ctrl_i.add) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      prod_q <= PROD_W'(sum_mag) * PROD_W'(scale_i);
      neg_q  <= sum_q[SUM_W-1];
    end
    if (ctrl_i.load) begin
      num_q <= num_full[PROD_W-1:8];
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  // saturate the signed quotient to the 32-bit range
  always_comb begin
    if (neg_q) begin
      if ((|num_q[NUM_W-1:Q_W]) || (num_q[Q_W-1] && (|num_q[Q_W-2:0]))) begin
        avg_o = Q_MIN;
      end else begin
        avg_o = -$signed(num_q[Q_W-1:0]);
      end
    end else begin
      if (|num_q[NUM_W-1:Q_W-1]) begin
        avg_o = Q_MAX;
      end else begin
        avg_o = $signed({1'b0, num_q[Q_W-2:0]});
      end
    end
  end

endmodule

// ===== sv/avsb_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsb_merge
// Combines the x and y lane averages with bias, keeps the bias registers,
// holds the output word.
// ----------------------------------------------------------------------------
module avsb_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  avsb_pkg::merge_ctrl_t             ctrl_i,
  input  logic signed [avsb_pkg::Q_W-1:0]   avg_x_i,
  input  logic signed [avsb_pkg::Q_W-1:0]   avg_y_i,
  input  logic signed [avsb_pkg::Q_W-1:0]   avg_z_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [3*avsb_pkg::Q_W-1:0]        out_data_o,
  output logic [1:0]                        out_user_o
);
  import avsb_pkg::*;

  logic signed [Q_W-1:0] bias_x_q, bias_y_q;
  logic signed [Q_W-1:0] sum_bx, sum_by, neg_x, neg_y;
  logic signed [Q_W-1:0] res_x, res_y, res_z;
  logic                  valid_q;
  logic [3*Q_W-1:0]      data_q;
  logic [1:0]            user_q;

  function automatic logic signed [Q_W-1:0] sat_add(
    input logic signed [Q_W-1:0] a,
    input logic signed [Q_W-1:0] b
  );
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return s[Q_W-1:0];
  endfunction

  assign sum_bx = sat_add(avg_x_i, bias_x_q);
  assign sum_by = sat_add(avg_y_i, bias_y_q);
  assign neg_x  = (avg_x_i == Q_MIN) ? Q_MAX : -avg_x_i;
  assign neg_y  = (avg_y_i == Q_MIN) ? Q_MAX : -avg_y_i;

  always_comb begin
    if (ctrl_i.empty) begin
      res_x = '0;
      res_y = '0;
      res_z = '0;
    end else if (ctrl_i.cal) begin
      res_x = avg_x_i;
      res_y = avg_y_i;
      res_z = avg_z_i;
    end else begin
      res_x = sum_bx;
      res_y = sum_by;
      res_z = avg_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      bias_x_q <= '0;
      bias_y_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
      if (ctrl_i.load && ctrl_i.cal && !ctrl_i.empty) begin
        bias_x_q <= neg_x;
        bias_y_q <= neg_y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= {res_z, res_y, res_x};
      user_q <= {ctrl_i.dropped, ctrl_i.empty};
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;

endmodule

// ===== sv/accel_average_scale_bias_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_average_scale_bias_top
// Three-axis accelerometer averaging with per-axis scale and bias calibration.
// ----------------------------------------------------------------------------
// Add-sample and clear words complete at the accepting edge. An evaluate or calibrate
// word runs in order: the per-axis scale multiply is taken at the accepting
// edge, the load state forms the rounded numerator, the divide state runs the
// bit-serial divide by the sample count in each axis lane and the done state
// writes the output register; with no samples held the word goes straight to
// the done state. Both take longer while an earlier result still waits
// in the output register. The input is ready only while no command is in
// progress; a finished result may still wait in the output register while
// new words are taken. Results are signed Q15.16 m/s^2, saturated.
module accel_average_scale_bias_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,  // raw_x, raw_y, raw_z
  input  logic [1:0]    s_axis_tuser,  // mode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [95:0]   m_axis_tdata,  // accel_x, accel_y, accel_z
  output logic [1:0]    m_axis_tuser,  // no_samples, samples_dropped
  input  logic          cfg_we_i,
  input  logic [avsb_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [avsb_pkg::SCALE_W-1:0]   cfg_data_i
);
  import avsb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;
  logic [CNT_W-1:0]  count_q, div_cnt_q;
  logic              dropped_q;
  logic [STEP_W-1:0] step_q;
  logic              cal_q, empty_q, drop_snap_q;
  logic              accept;
  mode_e             mode;
  lane_ctrl_t        lane_ctrl;
  merge_ctrl_t       merge_ctrl;
  logic signed [Q_W-1:0] avg_x, avg_y, avg_z;

  assign mode          = mode_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    lane_ctrl         = '0;
    lane_ctrl.add     = accept && (mode == MODE_ADD) && (count_q < MAX_SAMPLES);
    lane_ctrl.clear   = accept && (mode == MODE_CLEAR);
    lane_ctrl.capture = accept && ((mode == MODE_EVAL) || (mode == MODE_CAL));
    lane_ctrl.load    = (state_q == S_LOAD);
    lane_ctrl.step    = (state_q == S_DIV);
  end

  always_comb begin
    merge_ctrl.load    = (state_q == S_DONE) && (!m_axis_tvalid || m_axis_tready);
    merge_ctrl.cal     = cal_q;
    merge_ctrl.empty   = empty_q;
    merge_ctrl.dropped = drop_snap_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= SCALE_RESET;
      scale_y_q <= SCALE_RESET;
      scale_z_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_SCALE_X: scale_x_q <= cfg_data_i;
        REG_SCALE_Y: scale_y_q <= cfg_data_i;
        REG_SCALE_Z: scale_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      div_cnt_q   <= '0;
      step_q      <= '0;
      cal_q       <= 1'b0;
      empty_q     <= 1'b0;
      drop_snap_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_ADD: begin
                if (count_q < MAX_SAMPLES) begin
                  count_q <= count_q + CNT_W'(1);
                end else begin
                  dropped_q <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                count_q   <= '0;
                dropped_q <= 1'b0;
              end
              default: begin
                div_cnt_q   <= count_q;
                cal_q       <= (mode == MODE_CAL);
                empty_q     <= (count_q == '0);
                drop_snap_q <= dropped_q;
                count_q     <= '0;
                dropped_q   <= 1'b0;
                state_q     <= (count_q == '0) ? S_DONE : S_LOAD;
              end
            endcase
          end
        end
        S_LOAD: begin
          step_q  <= DIV_STEPS;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q - STEP_W'(1);
          if (step_q == STEP_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (merge_ctrl.load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  avsb_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .raw_i   (s_axis_tdata[15:0]),
    .scale_i (scale_x_q),
    .count_i (div_cnt_q),
    .avg_o   (avg_x)
  );

  avsb_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .raw_i   (s_axis_tdata[31:16]),
    .scale_i (scale_y_q),
    .count_i (div_cnt_q),
    .avg_o   (avg_y)
  );

  avsb_lane u_lane_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .raw_i   (s_axis_tdata[47:32]),
    .scale_i (scale_z_q),
    .count_i (div_cnt_q),
    .avg_o   (avg_z)
  );

  avsb_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (merge_ctrl),
    .avg_x_i     (avg_x),
    .avg_y_i     (avg_y),
    .avg_z_i     (avg_z),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the accelerometer averaging, scale and bias block.
// ----------------------------------------------------------------------------
// Sample, evaluate, calibrate and clear words are fed through the slave
// stream with random gaps. A predictor in the testbench keeps its own sums,
// count, bias and scales and queues the expected result of every evaluate
// and calibrate word. The monitor stalls the master stream at random and
// checks each result field by field against the oldest queued one. Scales
// are rewritten between phases while the block is idle.
module tb;
  import avsb_pkg::*;

  localparam int      SETTLE_CYCLES  = 60;
  localparam int      WATCHDOG_LIMIT = 4000;
  localparam longint  SUM_HI = 64'sd8388607;
  localparam longint  SUM_LO = -64'sd8388608;

  typedef struct {
    mode_e       mode;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rz;
  } in_word_t;

  typedef struct {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic               empty;
    logic               dropped;
  } accel_res_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [47:0]   s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [95:0]   m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [SCALE_W-1:0]   cfg_data_i = '0;

  // predictor state
  longint        sum_acc [3];
  int unsigned   held;
  longint        bias_acc [2];
  bit            drop_seen;
  logic [23:0]   scale_cfg [3];

  in_word_t      in_words_q [$];
  accel_res_t    accel_expect_q [$];
  in_word_t      cur_word;

  int            words_queued;
  int            words_accepted;
  int            results_checked;
  int            n_empty;
  int            n_dropped;
  int            n_sat;
  int            errors;
  int            src_gap, src_quiet, snk_gap, snk_quiet;
  int            idle_cycles;
  bit            src_busy;

  always #6 clk_i = ~clk_i;

  accel_average_scale_bias_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // round(sum * scale / (count * 256)), ties away from zero
  function automatic longint scaled_mean(input longint sum, input logic [23:0] scale,
                                         input int unsigned count);
    longint unsigned mag, den, q;
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    mag = mag * {40'd0, scale};
    den = longint'(count) * 256;
    q   = (mag + den / 2) / den;
    return (sum < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_acc();
    for (int k = 0; k < 3; k++) sum_acc[k] = 0;
    held      = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void accel_predict(input in_word_t w);
    accel_res_t r;
    longint     mean [3];
    longint     raw  [3];
    raw[0] = longint'($signed(w.rx));
    raw[1] = longint'($signed(w.ry));
    raw[2] = longint'($signed(w.rz));
    case (w.mode)
      MODE_ADD: begin
        if (held >= MAX_SAMPLES) begin
          drop_seen = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) sum_acc[k] = sat(sum_acc[k] + raw[k], SUM_LO, SUM_HI);
          held++;
        end
      end
      MODE_CLEAR: begin
        clear_acc();
      end
      default: begin
        for (int k = 0; k < 3; k++) mean[k] = 0;
        if (held != 0) begin
          for (int k = 0; k < 3; k++)
            mean[k] = sat(scaled_mean(sum_acc[k], scale_cfg[k], held),
                          longint'(Q_MIN), longint'(Q_MAX));
          if (w.mode == MODE_EVAL) begin
            for (int k = 0; k < 2; k++)
              mean[k] = sat(mean[k] + bias_acc[k], longint'(Q_MIN), longint'(Q_MAX));
          end else begin
            for (int k = 0; k < 2; k++)
              bias_acc[k] = sat(-mean[k], longint'(Q_MIN), longint'(Q_MAX));
          end
        end
        r.ax      = mean[0][31:0];
        r.ay      = mean[1][31:0];
        r.az      = mean[2][31:0];
        r.empty   = (held == 0);
        r.dropped = drop_seen;
        accel_expect_q.push_back(r);
        clear_acc();
      end
    endcase
  endfunction

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result();
    accel_res_t want;
    logic signed [31:0] gx, gy, gz;
    gx = m_axis_tdata[31:0];
    gy = m_axis_tdata[63:32];
    gz = m_axis_tdata[95:64];
    if (accel_expect_q.size() == 0) begin
      report_mismatch("unexpected result word", 1, 0);
      return;
    end
    want = accel_expect_q.pop_front();
    results_checked++;
    if (gx != want.ax) report_mismatch("accel_x", gx, want.ax);
    if (gy != want.ay) report_mismatch("accel_y", gy, want.ay);
    if (gz != want.az) report_mismatch("accel_z", gz, want.az);
    if (m_axis_tuser[0] != want.empty) report_mismatch("no_samples", m_axis_tuser[0], want.empty);
    if (m_axis_tuser[1] != want.dropped)
      report_mismatch("samples_dropped", m_axis_tuser[1], want.dropped);
    if (want.empty) n_empty++;
    if (want.dropped) n_dropped++;
    if (want.ax == Q_MAX || want.ax == Q_MIN || want.ay == Q_MAX || want.ay == Q_MIN) n_sat++;
  endtask

  // slave-side driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      src_busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        accel_predict(cur_word);
        words_accepted++;
        src_busy = 1'b0;
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (in_words_q.size() > 0) begin
          cur_word = in_words_q.pop_front();
          s_axis_tdata <= {cur_word.rz, cur_word.ry, cur_word.rx};
          s_axis_tuser <= cur_word.mode;
          src_busy = 1'b1;
          src_gap  = draw_gap(src_quiet);
        end
      end
      s_axis_tvalid <= src_busy;
    end
  end

  // master-side monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        snk_gap = draw_gap(snk_quiet);
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_word(input mode_e m, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z);
    in_word_t w;
    w.mode = m;
    w.rx   = x;
    w.ry   = y;
    w.rz   = z;
    in_words_q.push_back(w);
    words_queued++;
  endtask

  task automatic wait_idle();
    while (words_accepted != words_queued || accel_expect_q.size() != 0) @(posedge clk_i);
    // clear and add words leave no result behind to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    if (idx != REG_NONE) scale_cfg[int'(idx)] = val;
  endtask

  task automatic set_scales(input logic [23:0] sx, input logic [23:0] sy,
                            input logic [23:0] sz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_random(input int n);
    int start, run_len, pick;
    start = words_queued;
    while (words_queued - start < n) begin
      // a few runs go past the sample limit
      run_len = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 262) : $urandom_range(0, 24);
      repeat (run_len) push_word(MODE_ADD, pick_raw(), pick_raw(), pick_raw());
      pick = $urandom_range(0, 99);
      if (pick < 45)      push_word(MODE_EVAL, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 75) push_word(MODE_CAL, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 90) push_word(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 99) < 8)
        push_word(mode_e'($urandom_range(1, 3)), pick_raw(), pick_raw(), pick_raw());
    end
  endtask

  initial begin
    for (int k = 0; k < 3; k++) scale_cfg[k] = SCALE_RESET;
    bias_acc[0] = 0;
    bias_acc[1] = 0;
    clear_acc();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // commands on an empty set, extremes, bias use and clears
    push_word(MODE_EVAL,  16'h0000, 16'h0000, 16'h0000);
    push_word(MODE_CAL,   16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(MODE_ADD,   16'h7FFF, 16'h8000, 16'h0000);
    push_word(MODE_ADD,   16'h8000, 16'h7FFF, 16'hFFFF);
    push_word(MODE_ADD,   16'h0001, 16'hFFFF, 16'h7FFF);
    push_word(MODE_EVAL,  16'h0000, 16'h0000, 16'h0000);
    push_word(MODE_ADD,   16'hFF00, 16'h0100, 16'h0003);
    push_word(MODE_ADD,   16'hFE00, 16'h0300, 16'h0002);
    push_word(MODE_CAL,   16'h0000, 16'h0000, 16'h0000);
    push_word(MODE_ADD,   16'h0064, 16'hFF9C, 16'h0005);
    push_word(MODE_EVAL,  16'h0000, 16'h0000, 16'h0000);
    push_word(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    push_word(MODE_ADD,   16'h0007, 16'h0007, 16'h0007);
    push_word(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(MODE_EVAL,  16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // full scale: a large bias pushes the sum into saturation both ways
    set_scales(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    repeat (2) push_word(MODE_ADD, 16'h8000, 16'h8000, 16'h8000);
    push_word(MODE_CAL, 16'h0000, 16'h0000, 16'h0000);
    repeat (2) push_word(MODE_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_word(MODE_EVAL, 16'h0000, 16'h0000, 16'h0000);
    repeat (2) push_word(MODE_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_word(MODE_CAL, 16'h0000, 16'h0000, 16'h0000);
    repeat (2) push_word(MODE_ADD, 16'h8000, 16'h8000, 16'h8000);
    push_word(MODE_EVAL, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_NONE, 24'($urandom));
          set_scales(24'h000000, 24'h000000, 24'h000000);
        end
        1: set_scales(24'($urandom), 24'($urandom), 24'($urandom));
        2: set_scales(24'($urandom), 24'hFFFFFF, 24'h000001);
        default: set_scales(SCALE_RESET, 24'($urandom_range(0, 4095)), 24'hFFFFFF);
      endcase
      fill_random(440);
      wait_idle();
    end

    if (accel_expect_q.size() != 0)
      report_mismatch("results never delivered", 0, accel_expect_q.size());
    $display("run covered %0d input words and %0d result words over 6 scale settings",
             words_accepted, results_checked);
    $display("results with no samples: %0d, with dropped samples: %0d, saturated: %0d",
             n_empty, n_dropped, n_sat);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/avsb_pkg.sv
sv/avsb_lane.sv
sv/avsb_merge.sv
sv/accel_average_scale_bias_top.sv
tb/sv/tb.sv
